// ===== hw/rtl/xtea_pkg.sv =====
// XTEA encrypt package: shared types, constants and round helpers.
`timescale 1ns / 1ps

package xtea_pkg;

    localparam int CYCLE_COUNT = 32;
    localparam int WORD_W      = 32;
    localparam int BLOCK_W     = 2 * WORD_W;
    localparam int CFG_IDX_W   = 3;
    localparam int MIX_SHL     = 4;
    localparam int MIX_SHR     = 5;
    localparam int SEL_HI_LSB  = 11;

    typedef logic [WORD_W-1:0] xtea_word_t;

    // Key words, entry i is key_word_i
    typedef xtea_word_t [3:0] xtea_key_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD_0 = 3'd0,
        REG_KEY_WORD_1 = 3'd1,
        REG_KEY_WORD_2 = 3'd2,
        REG_KEY_WORD_3 = 3'd3,
        REG_ROUND_DELTA = 3'd4
    } xtea_reg_idx_t;

    // One slot of the pipeline
    typedef struct packed {
        logic       valid;
        xtea_word_t a;
        xtea_word_t b;
        xtea_word_t sum;
    } xtea_stage_t;

    function automatic xtea_word_t xtea_mix(input xtea_word_t w);
        xtea_mix = ((w << MIX_SHL) ^ (w >> MIX_SHR)) + w;
    endfunction

endpackage

// ===== hw/rtl/xtea_block_encrypt_unit.sv =====
// XTEA block encryption: fully unrolled pipeline, one 64-bit block per clock while the skid slot is free.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   plain_first, plain_second
//  m_axis    out        m_axis_tvalid/tready   cipher_first, cipher_second
//  cfg       in         cfg_we (no ready)      cfg_index selects register, cfg_wdata
//
//  There is one register stage per half-round, plus the output register.
//  One transaction accepted per clock when the sink keeps up.
//  All stages advance together; a two-entry output buffer (output register + skid)
//  lets the sink stall without losing a result, and the pipeline freezes only
//  while the skid slot is full. Reset clears valid bits, keys to zero and the
//  delta to 0x9E3779B9; no clearing pass is needed.

module xtea_block_encrypt_unit
    import xtea_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BLOCK_W-1:0]    s_axis_tdata,   // [31:0] plain_first, [63:32] plain_second

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BLOCK_W-1:0]    m_axis_tdata,   // [31:0] cipher_first, [63:32] cipher_second

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_wdata
);

    localparam xtea_word_t DELTA_RESET = 32'h9E37_79B9;

    xtea_key_t   key_reg;
    xtea_word_t  delta_reg;
    logic        en;
    xtea_stage_t stage [0:CYCLE_COUNT];

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            delta_reg <= DELTA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_WORD_0:  key_reg[0] <= cfg_wdata;
                REG_KEY_WORD_1:  key_reg[1] <= cfg_wdata;
                REG_KEY_WORD_2:  key_reg[2] <= cfg_wdata;
                REG_KEY_WORD_3:  key_reg[3] <= cfg_wdata;
                REG_ROUND_DELTA: delta_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Entry into the pipe: sum starts at zero for every block
    assign s_axis_tready = en;

    always_comb
    begin
        stage[0].valid = s_axis_tvalid;
        stage[0].a     = s_axis_tdata[WORD_W-1:0];
        stage[0].b     = s_axis_tdata[BLOCK_W-1:WORD_W];
        stage[0].sum   = '0;
    end

    for (genvar i = 0; i < CYCLE_COUNT; i++)
    begin : g_round
        xtea_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .key       (key_reg),
            .delta     (delta_reg),
            .in_stage  (stage[i]),
            .out_stage (stage[i+1])
        );
    end

    xtea_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .last_stage    (stage[CYCLE_COUNT]),
        .en            (en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // A frozen pipe holds its last-stage block until the skid drains
    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(stage[CYCLE_COUNT].a) && $stable(stage[CYCLE_COUNT].b)))
        else $error("pipeline moved while stalled");

    // Stage one sees the block accepted on the previous edge
    a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> g_round[0].u_round.mid_reg.valid)
        else $error("accepted transaction lost at pipe entry");

    // A bubble accepted at the input never becomes valid in stage one
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !s_axis_tvalid) |=> !g_round[0].u_round.mid_reg.valid)
        else $error("invented transaction at pipe entry");
`endif

endmodule

// ===== hw/rtl/xtea_round.sv =====
// One XTEA cycle: two half-rounds, each in its own register stage.
`timescale 1ns / 1ps

module xtea_round
    import xtea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  xtea_key_t   key,
    input  xtea_word_t  delta,
    input  xtea_stage_t in_stage,
    output xtea_stage_t out_stage
);

    xtea_stage_t mid_reg;
    xtea_stage_t mid_next;
    xtea_stage_t out_reg;
    xtea_stage_t out_next;

    // First half: update a, key by sum[1:0], then advance sum
    always_comb
    begin
        mid_next       = in_stage;
        mid_next.a     = in_stage.a
                       + (xtea_mix(in_stage.b) ^ (in_stage.sum + key[in_stage.sum[1:0]]));
        mid_next.sum   = in_stage.sum + delta;
    end

    // Second half: update b, key by sum[12:11]
    always_comb
    begin
        out_next   = mid_reg;
        out_next.b = mid_reg.b
                   + (xtea_mix(mid_reg.a)
                      ^ (mid_reg.sum + key[mid_reg.sum[SEL_HI_LSB+1:SEL_HI_LSB]]));
    end

    // Only the valid bits are reset; data follows them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg.valid <= 1'b0;
            out_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            mid_reg <= mid_next;
            out_reg <= out_next;
        end
    end

    assign out_stage = out_reg;

endmodule

// ===== hw/rtl/xtea_out_buf.sv =====
// Output register plus skid slot between the pipeline and the result stream.
`timescale 1ns / 1ps

module xtea_out_buf
    import xtea_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  xtea_stage_t         last_stage,
    output logic                en,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [BLOCK_W-1:0]  m_axis_tdata
);

    logic               out_valid_reg;
    logic [BLOCK_W-1:0] out_data_reg;
    logic               skid_valid_reg;
    logic [BLOCK_W-1:0] skid_data_reg;
    logic [BLOCK_W-1:0] last_data;

    // Pipeline runs while the skid slot is free
    assign en        = !skid_valid_reg;
    assign last_data = {last_stage.b, last_stage.a};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_axis_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (last_stage.valid)
        begin
            if (out_valid_reg && !m_axis_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (last_stage.valid)
        begin
            if (out_valid_reg && !m_axis_tready)
                skid_data_reg <= last_data;
            else
                out_data_reg <= last_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A parked result implies the output register is occupied
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output register empty");

    // Skid fills only when a result arrives against a blocked output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_valid_reg && last_stage.valid && out_valid_reg && !m_axis_tready)
        |=> (skid_valid_reg && skid_data_reg == $past(last_data)))
        else $error("result not parked in skid slot");

    // Draining the skid moves its data to the output register
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_axis_tready)
        |=> (!skid_valid_reg && out_valid_reg && out_data_reg == $past(skid_data_reg)))
        else $error("skid slot drained incorrectly");
`endif

endmodule

// ===== verif/xtea_block_encrypt_unit_tb.sv =====
// Self-checking testbench for the XTEA block encryption unit.
`timescale 1ns / 1ps

module xtea_block_encrypt_unit_tb
    import xtea_pkg::*;
();

    localparam int          LATENCY        = 2 * CYCLE_COUNT + 1;
    localparam int          IDLE_LIMIT     = 4000;
    localparam int          REPORT_MAX     = 10;
    localparam int          RANDOM_PHASES  = 10;
    localparam int          PHASE_ITEMS    = 175;
    localparam xtea_word_t  STD_DELTA      = 32'h9E37_79B9;
    localparam xtea_word_t  ALL_ONES       = '1;
    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNMAPPED = CFG_IDX_W'(REG_ROUND_DELTA + 1);
    localparam logic [CFG_IDX_W-1:0] IDX_LAST_UNMAPPED  = '1;

    // Packed so that the first field lands in the low bits of tdata
    typedef struct packed {
        xtea_word_t plain_second;
        xtea_word_t plain_first;
    } plain_block_t;

    typedef struct packed {
        xtea_word_t cipher_second;
        xtea_word_t cipher_first;
    } cipher_block_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BLOCK_W-1:0]   s_axis_tdata  = '0;   // [31:0] plain_first, [63:32] plain_second
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BLOCK_W-1:0]   m_axis_tdata;         // [31:0] cipher_first, [63:32] cipher_second
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [WORD_W-1:0]    cfg_wdata     = '0;

    // Local copy of the key schedule registers, kept in step with every write
    xtea_key_t            key_shadow    = '0;
    xtea_word_t           delta_shadow  = STD_DELTA;

    plain_block_t         plain_pending_q[$];
    cipher_block_t        cipher_expect_q[$];

    int unsigned          src_wait      = 0;
    int unsigned          sink_wait     = 0;
    bit                   src_steady    = 1'b0;
    bit                   sink_steady   = 1'b0;
    int unsigned          mismatch_count = 0;
    int unsigned          error_count   = 0;
    int unsigned          idle_run      = 0;

    xtea_block_encrypt_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------
    function automatic xtea_word_t feistel_f(input xtea_word_t w);
        feistel_f = ((w << 4) ^ (w >> 5)) + w;
    endfunction

    // Full XTEA encipher with the shadow key and delta. Sum wraps at 32 bits;
    // first half-round keys off sum[1:0], second off sum[12:11] after the add.
    function automatic cipher_block_t xtea_encipher(input plain_block_t blk);
        xtea_word_t    v0;
        xtea_word_t    v1;
        xtea_word_t    acc;
        cipher_block_t res;
        v0  = blk.plain_first;
        v1  = blk.plain_second;
        acc = '0;
        for (int c = 0; c < CYCLE_COUNT; c++)
        begin
            v0  = v0 + (feistel_f(v1) ^ (acc + key_shadow[acc[1:0]]));
            acc = acc + delta_shadow;
            v1  = v1 + (feistel_f(v0) ^ (acc + key_shadow[acc[12:11]]));
        end
        res.cipher_first  = v0;
        res.cipher_second = v1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Source driver: one plaintext block per beat, random gap (none if steady) after each
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : plain_driver
        plain_block_t next_blk;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_wait      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                cipher_expect_q.push_back(xtea_encipher(plain_block_t'(s_axis_tdata)));
            // tvalid is assigned once per edge so a back-to-back transaction
            // keeps it high without a glitch
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_wait != 0)
                begin
                    src_wait      <= src_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (plain_pending_q.size() != 0)
                begin
                    next_blk      = plain_pending_q.pop_front();
                    s_axis_tdata  <= next_blk;
                    s_axis_tvalid <= 1'b1;
                    src_wait      <= src_steady ? 0 : $urandom_range(15, 0);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each ciphertext transaction in order and
    // stalls tready (unless sink_steady) for a random number of cycles per result
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : cipher_monitor
        int unsigned   next_wait;
        cipher_block_t got;
        cipher_block_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end
        else
        begin
            next_wait = sink_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = cipher_block_t'(m_axis_tdata);
                if (cipher_expect_q.size() == 0)
                begin
                    error_count++;
                    if (mismatch_count++ < REPORT_MAX)
                        $display("[%0t] unexpected result first=%h second=%h",
                                 $realtime, got.cipher_first, got.cipher_second);
                end
                else
                begin
                    want = cipher_expect_q.pop_front();
                    if (got.cipher_first !== want.cipher_first ||
                        got.cipher_second !== want.cipher_second)
                    begin
                        error_count++;
                        if (mismatch_count++ < REPORT_MAX)
                            $display("[%0t] mismatch: first exp=%h act=%h, second exp=%h act=%h",
                                     $realtime, want.cipher_first, got.cipher_first,
                                     want.cipher_second, got.cipher_second);
                    end
                end
                next_wait = sink_steady ? 0 : $urandom_range(15, 0);
            end
            if (next_wait != 0)
            begin
                m_axis_tready <= 1'b0;
                sink_wait     <= next_wait - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                sink_wait     <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: consecutive cycles without any transaction or register write
    // ------------------------------------------------------------------
    initial
    begin
        while (idle_run < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input xtea_word_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
                key_shadow[idx[1:0]] = value;
            REG_ROUND_DELTA:
                delta_shadow = value;
            default: ;  // unmapped index, write is dropped
        endcase
    endtask

    // Loads the whole key schedule, with a stray write to an unmapped index
    // in the middle that must not disturb anything
    task automatic load_key_schedule(input xtea_word_t k0, input xtea_word_t k1,
                                     input xtea_word_t k2, input xtea_word_t k3,
                                     input xtea_word_t delta);
        write_reg(REG_KEY_WORD_0, k0);
        write_reg(REG_KEY_WORD_1, k1);
        write_reg(CFG_IDX_W'($urandom_range(IDX_LAST_UNMAPPED, IDX_FIRST_UNMAPPED)), $urandom);
        write_reg(REG_KEY_WORD_2, k2);
        write_reg(REG_KEY_WORD_3, k3);
        write_reg(REG_ROUND_DELTA, delta);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Block until every queued block went in and every result came back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (plain_pending_q.size() != 0 || s_axis_tvalid || cipher_expect_q.size() != 0);
    endtask

    task automatic queue_plain(input xtea_word_t first, input xtea_word_t second);
        plain_block_t blk;
        blk.plain_first  = first;
        blk.plain_second = second;
        plain_pending_q.push_back(blk);
    endtask

    // Mostly uniform words, with the all-zero and all-one corners mixed in
    function automatic xtea_word_t pick_word();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_corner_blocks();
        queue_plain('0, ALL_ONES);
        queue_plain(ALL_ONES, '0);
        queue_plain(32'h8000_0000, 32'h0000_0001);
        queue_plain(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        xtea_word_t delta_pick;
        int unsigned split;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset key schedule: all-zero key, standard delta
        queue_plain('0, '0);
        queue_plain(ALL_ONES, ALL_ONES);
        queue_plain(32'h0123_4567, 32'h89AB_CDEF);
        queue_plain(32'hDEAD_BEEF, 32'h0000_0000);
        queue_corner_blocks();
        wait_drained();

        // All-ones key and delta
        load_key_schedule(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        queue_corner_blocks();
        wait_drained();

        // Zero delta: sum never moves, only key word 0 is ever selected
        load_key_schedule($urandom, $urandom, $urandom, $urandom, '0);
        queue_corner_blocks();
        wait_drained();

        // Everything zero
        load_key_schedule('0, '0, '0, '0, '0);
        queue_corner_blocks();
        wait_drained();

        // Random phases, each under a fresh key schedule
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(3, 0))
                0:       delta_pick = STD_DELTA;
                1:       delta_pick = pick_word();
                default: delta_pick = $urandom;
            endcase
            load_key_schedule(pick_word(), pick_word(), pick_word(), pick_word(), delta_pick);
            @(negedge clk);
            src_steady  = ($urandom_range(3, 0) == 0);
            sink_steady = ($urandom_range(3, 0) == 0);

            // Sometimes hold the source until the pipeline is empty mid-phase
            split = (ph == 0 || $urandom_range(2, 0) == 0)
                    ? $urandom_range(PHASE_ITEMS - 1, 1) : PHASE_ITEMS;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == split)
                    wait_drained();
                queue_plain(pick_word(), pick_word());
            end
            wait_drained();
        end

        src_steady  = 1'b0;
        sink_steady = 1'b0;
        wait_drained();
        repeat (LATENCY + 20) @(negedge clk);
        if (cipher_expect_q.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/xtea_pkg.sv
hw/rtl/xtea_round.sv
hw/rtl/xtea_out_buf.sv
hw/rtl/xtea_block_encrypt_unit.sv
verif/xtea_block_encrypt_unit_tb.sv
